// File: rtl/bmms_pkg.sv
// Package for the boot memory-map scanner: sizes, region type codes, status codes,
// register indexes and the structures passed between the front end, queue and back end.
// Depends on nothing; every other file of the block imports it.
package bmms_pkg;

   // Scan limits and alignment.
   localparam int TYPE_COUNT  = 8;
   localparam int ALIGN_ORDER = 10;
   localparam int MAX_SPANS   = 16;
   localparam int MAX_USABLE  = 32;
   localparam int MAX_RECLAIM = 16;

   // Field widths.
   localparam int PAGE_SHIFT   = 12;
   localparam int ADDR_W       = 64;
   localparam int TYPE_FIELD_W = 4;
   localparam int PFN_W        = ADDR_W - PAGE_SHIFT;
   localparam int LIMIT_W      = PFN_W + 1;
   localparam int ALIGN_W      = LIMIT_W + 1;
   localparam int SPAN_IDX_W   = 4;

   // Counter and index widths.
   localparam int TYPE_IDX_W  = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
   localparam int USED_W      = $clog2(MAX_USABLE + 1);
   localparam int RECL_W      = $clog2(MAX_RECLAIM + 1);
   localparam int SPAN_CNT_W  = $clog2(MAX_SPANS + 1);

   // Constant values.
   localparam logic [ALIGN_W-1:0] ALIGN_MASK = ALIGN_W'((64'd1 << ALIGN_ORDER) - 64'd1);
   localparam logic [PFN_W-1:0]   TOTAL_MAX  = {PFN_W{1'b1}};
   localparam logic [LIMIT_W-1:0] LIMIT_MAX  = {LIMIT_W{1'b1}};
   localparam logic [LIMIT_W-1:0] LOW_LIMIT_RESET = LIMIT_W'(64'h100000 >> PAGE_SHIFT);
   localparam logic [LIMIT_W-1:0] MAP_LIMIT_RESET = LIMIT_W'(64'd67108864);

   // Region type codes.
   localparam logic [TYPE_FIELD_W-1:0] RTYPE_USABLE       = TYPE_FIELD_W'(0);
   localparam logic [TYPE_FIELD_W-1:0] RTYPE_RECLAIM      = TYPE_FIELD_W'(1);
   localparam logic [TYPE_FIELD_W-1:0] RTYPE_MANAGED_LAST = TYPE_FIELD_W'(4);

   // Register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_LIMIT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_LIMIT = 1'b1;

   // Queue between the front and back ends.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_PASS    = 2'd0,
      STATUS_BAD     = 2'd1,
      STATUS_ABORTED = 2'd2
   } bmms_status_type;

   // First front-end stage: decoded frame numbers.
   typedef struct packed {
      logic                    start;
      logic                    err;
      logic [TYPE_FIELD_W-1:0] rtype;
      logic [PFN_W-1:0]        sp;
      logic [PFN_W-1:0]        lenp;
      logic [LIMIT_W-1:0]      ep;
   } bmms_decode_type;

   // Classified region as queued for the back end.
   typedef struct packed {
      logic                    start;
      logic                    err;
      logic [TYPE_FIELD_W-1:0] rtype;
      logic [PFN_W-1:0]        lenp;
      logic [PFN_W-1:0]        lowres_delta;
      logic [PFN_W-1:0]        unmap_delta;
      logic                    usable_hit;
      logic [PFN_W-1:0]        usable_start;
      logic [LIMIT_W-1:0]      usable_end;
      logic                    span_hit;
      logic [LIMIT_W-1:0]      span_start;
      logic [LIMIT_W-1:0]      span_end;
   } bmms_item_type;

endpackage

// File: rtl/bmms_req_if.sv
// Region request channel: valid/ready handshake with the region fields.
// Depends on bmms_pkg for field widths.
interface bmms_req_if import bmms_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    start_new_scan;
   logic [ADDR_W-1:0]       region_base;
   logic [ADDR_W-1:0]       region_length;
   logic [TYPE_FIELD_W-1:0] region_type;

   modport source (output valid, start_new_scan, region_base, region_length, region_type,
                   input ready);
   modport sink   (input valid, start_new_scan, region_base, region_length, region_type,
                   output ready);
endinterface

// File: rtl/bmms_rsp_if.sv
// Result channel: valid/ready handshake with the per-region result fields.
// Depends on bmms_pkg for field widths and the status type.
interface bmms_rsp_if import bmms_pkg::*; ();
   logic                  valid;
   logic                  ready;
   bmms_status_type       status;
   logic [PFN_W-1:0]      type_pages_total;
   logic [PFN_W-1:0]      low_reserved_total;
   logic [PFN_W-1:0]      unmapped_total;
   logic                  usable_emitted;
   logic [PFN_W-1:0]      usable_start;
   logic [LIMIT_W-1:0]    usable_end;
   logic                  reclaim_recorded;
   logic                  span_touched;
   logic [SPAN_IDX_W-1:0] span_index;
   logic [LIMIT_W-1:0]    span_start;
   logic [LIMIT_W-1:0]    span_end;

   modport source (output valid, status, type_pages_total, low_reserved_total,
                   unmapped_total, usable_emitted, usable_start, usable_end,
                   reclaim_recorded, span_touched, span_index, span_start, span_end,
                   input ready);
   modport sink   (input valid, status, type_pages_total, low_reserved_total,
                   unmapped_total, usable_emitted, usable_start, usable_end,
                   reclaim_recorded, span_touched, span_index, span_start, span_end,
                   output ready);
endinterface

// File: rtl/bmms_front.sv
// Front end: two pipeline stages that check each region and clip it against the limits.
// Depends on bmms_pkg; feeds bmms_queue.
module bmms_front import bmms_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic                    start_new_scan,
   input  logic [ADDR_W-1:0]       region_base,
   input  logic [ADDR_W-1:0]       region_length,
   input  logic [TYPE_FIELD_W-1:0] region_type,
   input  logic [LIMIT_W-1:0]      low_limit_pfn,
   input  logic [LIMIT_W-1:0]      map_limit_pfn,
   output logic                    push,
   output bmms_item_type           push_item
);

   logic            dec_valid_ff;
   bmms_decode_type dec_ff;
   bmms_decode_type dec_in;
   logic            item_valid_ff;
   bmms_item_type   item_ff;
   bmms_item_type   item_in;

   logic [LIMIT_W-1:0] sp_ext;
   logic [LIMIT_W-1:0] lo_end;
   logic [LIMIT_W-1:0] hi_start;
   logic [LIMIT_W-1:0] us;
   logic [LIMIT_W-1:0] ue;
   logic [ALIGN_W-1:0] round_sum;
   logic [ALIGN_W-1:0] round_end;
   logic               is_usable;
   logic               is_managed;

   // Stage one: alignment and type checks, frame numbers and the end frame.
   always_comb begin
      dec_in.start = start_new_scan;
      dec_in.err   = (region_base[PAGE_SHIFT-1:0] != '0)
                   || (region_length[PAGE_SHIFT-1:0] != '0)
                   || ({1'b0, region_type} >= (TYPE_FIELD_W + 1)'(TYPE_COUNT));
      dec_in.rtype = region_type;
      dec_in.sp    = region_base[ADDR_W-1:PAGE_SHIFT];
      dec_in.lenp  = region_length[ADDR_W-1:PAGE_SHIFT];
      dec_in.ep    = {1'b0, dec_in.sp} + {1'b0, dec_in.lenp};
   end

   // Stage two: split at the low and map limits and widen to the span alignment.
   always_comb begin
      sp_ext     = {1'b0, dec_ff.sp};
      is_usable  = (dec_ff.rtype == RTYPE_USABLE);
      is_managed = (dec_ff.rtype <= RTYPE_MANAGED_LAST);
      lo_end     = (dec_ff.ep < low_limit_pfn) ? dec_ff.ep : low_limit_pfn;
      hi_start   = (sp_ext > map_limit_pfn) ? sp_ext : map_limit_pfn;
      us         = (sp_ext > low_limit_pfn) ? sp_ext : low_limit_pfn;
      ue         = (dec_ff.ep < map_limit_pfn) ? dec_ff.ep : map_limit_pfn;
      round_sum  = {1'b0, ue} + ALIGN_MASK;
      round_end  = round_sum & ~ALIGN_MASK;

      item_in.start        = dec_ff.start;
      item_in.err          = dec_ff.err;
      item_in.rtype        = dec_ff.rtype;
      item_in.lenp         = dec_ff.lenp;
      item_in.lowres_delta = (is_usable && (sp_ext < lo_end)) ?
                             PFN_W'(lo_end - sp_ext) : '0;
      item_in.unmap_delta  = (is_usable && (hi_start < dec_ff.ep)) ?
                             PFN_W'(dec_ff.ep - hi_start) : '0;
      item_in.usable_hit   = is_usable && (us < ue);
      item_in.usable_start = item_in.usable_hit ? us[PFN_W-1:0] : '0;
      item_in.usable_end   = item_in.usable_hit ? ue : '0;
      item_in.span_hit     = is_managed && (sp_ext < ue);
      item_in.span_start   = sp_ext & ~ALIGN_MASK[LIMIT_W-1:0];
      item_in.span_end     = round_end[LIMIT_W] ? LIMIT_MAX : round_end[LIMIT_W-1:0];
   end

   // Pipeline registers; the queue always has room for what is in flight here.
   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff  <= 1'b0;
         item_valid_ff <= 1'b0;
      end else begin
         dec_valid_ff  <= accept;
         item_valid_ff <= dec_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      dec_ff  <= dec_in;
      item_ff <= item_in;
   end

   assign push      = item_valid_ff;
   assign push_item = item_ff;

endmodule

// File: rtl/bmms_queue.sv
// Short queue between the front and back ends, with a credit count that covers
// regions still in the front pipeline. Depends on bmms_pkg.
module bmms_queue import bmms_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic          push,
   input  bmms_item_type push_item,
   input  logic          pop,
   output logic          room,
   output logic          head_valid,
   output bmms_item_type head_item
);

   bmms_item_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic [QCNT_W-1:0]   credit_ff;
   logic [QCNT_W-1:0]   credit_in;

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = QCNT_W'(count_ff + QCNT_W'(push) - QCNT_W'(pop));
      credit_in = QCNT_W'(credit_ff + QCNT_W'(accept) - QCNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         credit_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         credit_ff <= credit_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign room       = (credit_ff < QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> ((count_ff != QCNT_W'(QUEUE_DEPTH)) || pop))
      else $error("queue written while full");
   a_credit_covers: assert property (@(posedge clock) disable iff (reset)
      count_ff <= credit_ff)
      else $error("queue holds more entries than outstanding credits");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue read while empty");
`endif

endmodule

// File: rtl/bmms_back.sv
// Back end: per-type totals, counters, last-span merge and the registered result.
// Depends on bmms_pkg and bmms_rsp_if; takes its regions from bmms_queue.
module bmms_back import bmms_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  bmms_item_type head_item,
   output logic          pop,
   bmms_rsp_if.source    rsp_ch
);

   // Scan state.
   logic [PFN_W-1:0]      totals_ff [TYPE_COUNT];
   logic [PFN_W-1:0]      totals_in [TYPE_COUNT];
   logic [PFN_W-1:0]      lowres_ff, lowres_in;
   logic [PFN_W-1:0]      unmap_ff, unmap_in;
   logic [USED_W-1:0]     ucount_ff, ucount_in;
   logic [RECL_W-1:0]     rcount_ff, rcount_in;
   logic [SPAN_CNT_W-1:0] scount_ff, scount_in;
   logic [LIMIT_W-1:0]    sstart_ff, sstart_in;
   logic [LIMIT_W-1:0]    send_ff, send_in;
   logic                  failed_ff, failed_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   bmms_status_type       status_ff, status_in;
   logic [PFN_W-1:0]      tot_out_ff, tot_out_in;
   logic [PFN_W-1:0]      lowres_out_ff, lowres_out_in;
   logic [PFN_W-1:0]      unmap_out_ff, unmap_out_in;
   logic                  uemit_ff, uemit_in;
   logic [PFN_W-1:0]      ustart_ff, ustart_in;
   logic [LIMIT_W-1:0]    uend_ff, uend_in;
   logic                  rrec_ff, rrec_in;
   logic                  touched_ff, touched_in;
   logic [SPAN_IDX_W-1:0] sidx_ff, sidx_in;
   logic [LIMIT_W-1:0]    sstart_out_ff, sstart_out_in;
   logic [LIMIT_W-1:0]    send_out_ff, send_out_in;

   // Working values for the region at the queue head.
   logic                  fire;
   logic                  start;
   logic [TYPE_IDX_W-1:0] tidx;
   logic [PFN_W-1:0]      tot_eff, lowres_eff, unmap_eff;
   logic [USED_W-1:0]     ucount_eff;
   logic [RECL_W-1:0]     rcount_eff;
   logic [SPAN_CNT_W-1:0] scount_eff;
   logic [LIMIT_W-1:0]    sstart_eff, send_eff;
   logic                  failed_eff;
   logic [PFN_W:0]        tot_sum, lowres_sum, unmap_sum;
   logic [PFN_W-1:0]      tot_new, lowres_new, unmap_new;
   logic                  is_reclaim;
   logic                  merge;
   logic                  fail_now;
   logic                  ok;
   logic [USED_W-1:0]     ucount_new;
   logic [RECL_W-1:0]     rcount_new;
   logic [SPAN_CNT_W-1:0] scount_new;
   logic [LIMIT_W-1:0]    sstart_new, send_new;

   assign fire = head_valid && (!rsp_valid_ff || rsp_ch.ready);
   assign pop  = fire;

   // State as seen by this region: a new scan starts from cleared state.
   always_comb begin
      start      = head_item.start;
      tidx       = head_item.rtype[TYPE_IDX_W-1:0];
      tot_eff    = start ? '0 : totals_ff[tidx];
      lowres_eff = start ? '0 : lowres_ff;
      unmap_eff  = start ? '0 : unmap_ff;
      ucount_eff = start ? '0 : ucount_ff;
      rcount_eff = start ? '0 : rcount_ff;
      scount_eff = start ? '0 : scount_ff;
      sstart_eff = start ? '0 : sstart_ff;
      send_eff   = start ? '0 : send_ff;
      failed_eff = start ? 1'b0 : failed_ff;
   end

   // Saturating totals, list capacity checks and the last-span merge.
   always_comb begin
      tot_sum    = {1'b0, tot_eff} + {1'b0, head_item.lenp};
      lowres_sum = {1'b0, lowres_eff} + {1'b0, head_item.lowres_delta};
      unmap_sum  = {1'b0, unmap_eff} + {1'b0, head_item.unmap_delta};
      tot_new    = tot_sum[PFN_W] ? TOTAL_MAX : tot_sum[PFN_W-1:0];
      lowres_new = lowres_sum[PFN_W] ? TOTAL_MAX : lowres_sum[PFN_W-1:0];
      unmap_new  = unmap_sum[PFN_W] ? TOTAL_MAX : unmap_sum[PFN_W-1:0];

      is_reclaim = (head_item.rtype == RTYPE_RECLAIM);
      merge      = (scount_eff != '0) && (head_item.span_start <= send_eff);
      fail_now   = head_item.err
                 || (is_reclaim && (rcount_eff >= RECL_W'(MAX_RECLAIM)))
                 || (head_item.usable_hit && (ucount_eff >= USED_W'(MAX_USABLE)))
                 || (head_item.span_hit && !merge
                     && (scount_eff >= SPAN_CNT_W'(MAX_SPANS)));
      ok         = !failed_eff && !fail_now;

      rcount_new = is_reclaim ? RECL_W'(rcount_eff + 1'b1) : rcount_eff;
      ucount_new = head_item.usable_hit ? USED_W'(ucount_eff + 1'b1) : ucount_eff;
      scount_new = scount_eff;
      sstart_new = sstart_eff;
      send_new   = send_eff;
      if (head_item.span_hit) begin
         if (merge) begin
            send_new = (head_item.span_end > send_eff) ? head_item.span_end : send_eff;
         end else begin
            scount_new = SPAN_CNT_W'(scount_eff + 1'b1);
            sstart_new = head_item.span_start;
            send_new   = head_item.span_end;
         end
      end
   end

   // Next scan state: a failing region sets the error flag and keeps the rest, cleared first if it starts a new scan.
   always_comb begin
      for (int i = 0; i < TYPE_COUNT; i++) begin
         totals_in[i] = (fire && start) ? '0 : totals_ff[i];
         if (fire && ok && (TYPE_IDX_W'(i) == tidx)) begin
            totals_in[i] = tot_new;
         end
      end
      lowres_in = lowres_ff;
      unmap_in  = unmap_ff;
      ucount_in = ucount_ff;
      rcount_in = rcount_ff;
      scount_in = scount_ff;
      sstart_in = sstart_ff;
      send_in   = send_ff;
      failed_in = failed_ff;
      if (fire) begin
         failed_in = failed_eff || fail_now;
         if (ok) begin
            lowres_in = lowres_new;
            unmap_in  = unmap_new;
            ucount_in = ucount_new;
            rcount_in = rcount_new;
            scount_in = scount_new;
            sstart_in = sstart_new;
            send_in   = send_new;
         end else begin
            lowres_in = lowres_eff;
            unmap_in  = unmap_eff;
            ucount_in = ucount_eff;
            rcount_in = rcount_eff;
            scount_in = scount_eff;
            sstart_in = sstart_eff;
            send_in   = send_eff;
         end
      end
   end

   // Result payload: everything but the status reads zero unless the region succeeds.
   always_comb begin
      rsp_valid_in  = fire ? 1'b1 : (rsp_valid_ff && !rsp_ch.ready);
      status_in     = failed_eff ? STATUS_ABORTED : (fail_now ? STATUS_BAD : STATUS_PASS);
      tot_out_in    = ok ? tot_new : '0;
      lowres_out_in = ok ? lowres_new : '0;
      unmap_out_in  = ok ? unmap_new : '0;
      uemit_in      = ok && head_item.usable_hit;
      ustart_in     = ok ? head_item.usable_start : '0;
      uend_in       = ok ? head_item.usable_end : '0;
      rrec_in       = ok && is_reclaim;
      touched_in    = ok && head_item.span_hit;
      sidx_in       = (ok && (scount_new != '0)) ? SPAN_IDX_W'(scount_new - 1'b1) : '0;
      sstart_out_in = ok ? sstart_new : '0;
      send_out_in   = ok ? send_new : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TYPE_COUNT; i++) begin
            totals_ff[i] <= '0;
         end
         lowres_ff    <= '0;
         unmap_ff     <= '0;
         ucount_ff    <= '0;
         rcount_ff    <= '0;
         scount_ff    <= '0;
         sstart_ff    <= '0;
         send_ff      <= '0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         totals_ff    <= totals_in;
         lowres_ff    <= lowres_in;
         unmap_ff     <= unmap_in;
         ucount_ff    <= ucount_in;
         rcount_ff    <= rcount_in;
         scount_ff    <= scount_in;
         sstart_ff    <= sstart_in;
         send_ff      <= send_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload is loaded only when a region is taken from the queue.
   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff     <= status_in;
         tot_out_ff    <= tot_out_in;
         lowres_out_ff <= lowres_out_in;
         unmap_out_ff  <= unmap_out_in;
         uemit_ff      <= uemit_in;
         ustart_ff     <= ustart_in;
         uend_ff       <= uend_in;
         rrec_ff       <= rrec_in;
         touched_ff    <= touched_in;
         sidx_ff       <= sidx_in;
         sstart_out_ff <= sstart_out_in;
         send_out_ff   <= send_out_in;
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.status             = status_ff;
   assign rsp_ch.type_pages_total   = tot_out_ff;
   assign rsp_ch.low_reserved_total = lowres_out_ff;
   assign rsp_ch.unmapped_total     = unmap_out_ff;
   assign rsp_ch.usable_emitted     = uemit_ff;
   assign rsp_ch.usable_start       = ustart_ff;
   assign rsp_ch.usable_end         = uend_ff;
   assign rsp_ch.reclaim_recorded   = rrec_ff;
   assign rsp_ch.span_touched       = touched_ff;
   assign rsp_ch.span_index         = sidx_ff;
   assign rsp_ch.span_start         = sstart_out_ff;
   assign rsp_ch.span_end           = send_out_ff;

`ifndef SYNTH
   a_failed_sticky: assert property (@(posedge clock) disable iff (reset)
      (failed_ff && !(fire && head_item.start)) |=> failed_ff)
      else $error("scan error cleared without a new scan");
   a_lists_bounded: assert property (@(posedge clock) disable iff (reset)
      (scount_ff <= SPAN_CNT_W'(MAX_SPANS)) && (ucount_ff <= USED_W'(MAX_USABLE))
      && (rcount_ff <= RECL_W'(MAX_RECLAIM)))
      else $error("list count beyond its capacity");
   a_fail_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (fire && !head_item.start && !ok)
      |=> ($stable(scount_ff) && $stable(send_ff) && $stable(lowres_ff)))
      else $error("failing region changed the scan state");
`endif

endmodule

// File: rtl/boot_memory_map_scanner.sv
// Boot memory-map scanner, top level: configuration registers and the front end,
// queue and back end. Depends on bmms_pkg, bmms_req_if, bmms_rsp_if and submodules.
//
// Usage. Regions arrive on req_ch, one per transfer, in ascending address order;
// start_new_scan on a region clears all totals, counts, the span and the error first.
// Each region yields exactly one result on rsp_ch, in the same order.
// csr_we writes csr_wdata into the low-limit (index 0) or map-limit (index 1) frame
// register; write only while no region is outstanding.
//
// A region accepted on req_ch passes through the two front-end stages, one queue slot
// and then the registered back end before its result is valid on rsp_ch.
// Throughput: one region per cycle while the receiver takes each result; the back end
// updates all scan state for a region as it leaves the queue, including the last-span merge.
// req_ch.ready is high while fewer than four regions sit between acceptance and the
// back end, so a stalled receiver fills the four-entry queue and then holds
// req_ch.ready low; the result register keeps its value until transferred.
// Reset: synchronous; clears all scan state and loads the limit registers with frame
// 256 and frame 67108864. No clearing pass is needed, so regions are accepted at once.
module boot_memory_map_scanner import bmms_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   bmms_req_if.sink               req_ch,
   bmms_rsp_if.source             rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [LIMIT_W-1:0]     csr_wdata
);

   logic [LIMIT_W-1:0] low_limit_ff, low_limit_in;
   logic [LIMIT_W-1:0] map_limit_ff, map_limit_in;
   logic               accept;
   logic               room;
   logic               push;
   bmms_item_type      push_item;
   logic               head_valid;
   bmms_item_type      head_item;
   logic               pop;

   // Configuration register writes.
   always_comb begin
      low_limit_in = low_limit_ff;
      map_limit_in = map_limit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LOW_LIMIT: low_limit_in = csr_wdata;
            CSR_MAP_LIMIT: map_limit_in = csr_wdata;
            default: begin
               low_limit_in = low_limit_ff;
               map_limit_in = map_limit_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_limit_ff <= LOW_LIMIT_RESET;
         map_limit_ff <= MAP_LIMIT_RESET;
      end else begin
         low_limit_ff <= low_limit_in;
         map_limit_ff <= map_limit_in;
      end
   end

   // Request handshake, gated by queue credits.
   assign req_ch.ready = room;
   assign accept       = req_ch.valid && room;

   bmms_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .start_new_scan (req_ch.start_new_scan),
      .region_base    (req_ch.region_base),
      .region_length  (req_ch.region_length),
      .region_type    (req_ch.region_type),
      .low_limit_pfn  (low_limit_ff),
      .map_limit_pfn  (map_limit_ff),
      .push           (push),
      .push_item      (push_item)
   );

   bmms_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .room       (room),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   bmms_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule
